// ===== hw/rtl/mnas_pkg.sv =====
package mnas_pkg;

    localparam int MaxBranches = 1024;

    localparam logic [2:0] KIND_RES  = 3'd0;
    localparam logic [2:0] KIND_ISRC = 3'd1;
    localparam logic [2:0] KIND_VSRC = 3'd2;
    localparam logic [2:0] KIND_IND  = 3'd3;

    localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] QNAN_BIT  = 64'h0008_0000_0000_0000;

    localparam int ListDepth = 5;

    typedef struct packed {
        logic        to_rhs;
        logic [10:0] row;
        logic [10:0] column;
        logic [63:0] value;
        logic        ovf;
    } stamp_t;

    typedef stamp_t [ListDepth-1:0] stamp_list_t;

    typedef enum logic [1:0] {
        RC_IDLE,
        RC_NORM,
        RC_DIV,
        RC_ROUND
    } recip_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_LOAD,
        ST_EMIT
    } seq_state_t;

    function automatic stamp_t mk_stamp(logic rhs, logic [10:0] r, logic [10:0] c,
                                        logic [63:0] v);
        stamp_t s;
        s.to_rhs = rhs;
        s.row    = r;
        s.column = c;
        s.value  = v;
        s.ovf    = 1'b0;
        return s;
    endfunction

endpackage

// ===== hw/rtl/mnas_recip.sv =====
module mnas_recip
    import mnas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] result
);

    recip_state_t state_reg, state_next;
    logic               sign_reg, sign_next;
    logic [52:0]        div_reg, div_next;
    logic [53:0]        rem_reg, rem_next;
    logic [53:0]        quo_reg, quo_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic signed [12:0] exp_reg, exp_next;
    logic [63:0]        result_reg, result_next;
    logic               done_reg, done_next;

    logic [10:0] op_exp;
    logic [51:0] op_frac;
    logic        rem_ge;
    logic [53:0] rem_diff;
    logic        sticky;
    logic [51:0] mant;
    logic        guard;
    logic        rsticky;
    logic        rnd;
    logic [62:0] packed_sum;
    logic [62:0] packed_base;

    assign op_exp   = operand[62:52];
    assign op_frac  = operand[51:0];
    assign rem_ge   = rem_reg >= {1'b0, div_reg};
    assign rem_diff = rem_reg - {1'b0, div_reg};
    assign sticky   = rem_reg != '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RC_IDLE:
            begin
                if (start && op_exp != 11'h7FF && (op_exp != '0 || op_frac != '0))
                begin
                    state_next = RC_NORM;
                end
            end
            RC_NORM:
            begin
                if (div_reg[52])
                begin
                    state_next = RC_DIV;
                end
            end
            RC_DIV:
            begin
                if (cnt_reg == 6'd53)
                begin
                    state_next = RC_ROUND;
                end
            end
            RC_ROUND:
            begin
                state_next = RC_IDLE;
            end
            default:
            begin
                state_next = RC_IDLE;
            end
        endcase
    end

    // final rounding, exponent kept as biased value of the quotient
    always_comb
    begin
        if (exp_reg == 13'sd0)
        begin
            mant    = quo_reg[53:2];
            guard   = quo_reg[1];
            rsticky = sticky | quo_reg[0];
        end
        else if (exp_reg < 13'sd0)
        begin
            mant    = {1'b0, quo_reg[53:3]};
            guard   = quo_reg[2];
            rsticky = sticky | quo_reg[1] | quo_reg[0];
        end
        else
        begin
            mant    = quo_reg[52:1];
            guard   = quo_reg[0];
            rsticky = sticky;
        end
        rnd = guard & (rsticky | mant[0]);
        if (exp_reg >= 13'sd1)
        begin
            packed_base = {exp_reg[10:0], mant};
        end
        else
        begin
            packed_base = {11'd0, mant};
        end
        packed_sum = packed_base + {62'd0, rnd};
    end

    // datapath
    always_comb
    begin
        sign_next   = sign_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        exp_next    = exp_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            RC_IDLE:
            begin
                if (start)
                begin
                    sign_next = operand[63];
                    if (op_exp == '0 && op_frac == '0)
                    begin
                        result_next = (operand & SIGN_BIT) | INF_BITS;
                        done_next   = 1'b1;
                    end
                    else if (op_exp == 11'h7FF)
                    begin
                        if (op_frac == '0)
                        begin
                            result_next = operand & SIGN_BIT;
                        end
                        else
                        begin
                            result_next = operand | QNAN_BIT;
                        end
                        done_next = 1'b1;
                    end
                    else if (op_exp == '0)
                    begin
                        div_next = {1'b0, op_frac};
                        exp_next = -13'sd1022;
                    end
                    else
                    begin
                        div_next = {1'b1, op_frac};
                        exp_next = $signed({2'b00, op_exp}) - 13'sd1023;
                    end
                end
            end
            RC_NORM:
            begin
                cnt_next = '0;
                quo_next = '0;
                if (div_reg[52])
                begin
                    // a mantissa of exactly one gives an exact power of two
                    if (div_reg[51:0] == '0)
                    begin
                        rem_next = 54'd1 << 52;
                        exp_next = 13'sd1023 - exp_reg;
                    end
                    else
                    begin
                        rem_next = 54'd1 << 53;
                        exp_next = 13'sd1022 - exp_reg;
                    end
                end
                else
                begin
                    div_next = {div_reg[51:0], 1'b0};
                    exp_next = exp_reg - 13'sd1;
                end
            end
            RC_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (rem_ge)
                begin
                    rem_next = {rem_diff[52:0], 1'b0};
                    quo_next = {quo_reg[52:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[52:0], 1'b0};
                    quo_next = {quo_reg[52:0], 1'b0};
                end
            end
            RC_ROUND:
            begin
                done_next = 1'b1;
                if (exp_reg >= 13'sd2047)
                begin
                    result_next = {sign_reg, INF_BITS[62:0]};
                end
                else
                begin
                    result_next = {sign_reg, packed_sum};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg   <= sign_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/mnas_emitter.sv =====
module mnas_emitter
    import mnas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  stamp_list_t list,
    input  logic [2:0]  count,
    input  logic        out_stall,
    output logic        out_valid,
    output stamp_t      entry,
    output logic        last
);

    stamp_list_t list_reg;
    logic [2:0]  count_reg;
    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic        at_end;

    assign at_end = (idx_reg == count_reg - 3'd1);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = '0;
            valid_next = count != '0;
        end
        else if (valid_reg && !out_stall)
        begin
            if (at_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            list_reg  <= list;
            count_reg <= count;
        end
    end

    assign out_valid = valid_reg;
    assign entry     = list_reg[idx_reg];
    assign last      = at_end;

endmodule

// ===== hw/rtl/mna_element_stamp_generator.sv =====
// timing: a resistor waits for the reciprocal unit (serial normalize plus 54-step
// divide), longer for a subnormal value; other kinds go straight to the list load
// throughput: one result transaction per cycle while out_stall is low; the next element
// is accepted only after the last transaction of the previous one is taken and the sequencer is back in idle
// reset: asynchronous active low, clears node_count, branch counter and all control
module mna_element_stamp_generator
    import mnas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // element input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [10:0] pos_node,
    input  logic [10:0] neg_node,
    input  logic [63:0] element_value,
    // stamp output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        to_rhs,
    output logic [10:0] row,
    output logic [10:0] column,
    output logic [63:0] entry_value,
    output logic        branch_overflow,
    output logic        last
);

    seq_state_t  state_reg, state_next;
    logic [10:0] node_count_reg;
    logic [10:0] branch_count_reg, branch_count_next;

    // element held for the whole transaction
    logic [2:0]  kind_reg;
    logic [10:0] p_reg;
    logic [10:0] n_reg;
    logic [63:0] v_reg;

    logic        in_fire;
    logic        recip_start;
    logic        recip_done;
    logic [63:0] recip_g;
    logic        emit_load;
    logic        emit_busy;
    stamp_t      emit_entry;

    stamp_list_t list;
    logic [2:0]  list_count;
    logic        p_live;
    logic        n_live;
    logic        br_full;
    logic        is_branch;
    logic [10:0] brow;
    logic [63:0] neg_g;

    // register file: only node_count, at every address with paddr[2] clear
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {21'd0, node_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            node_count_reg <= pwdata[10:0];
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_fire     = in_valid && !in_stall;
    // reciprocal starts straight from the input bus
    assign recip_start = in_fire && (req_type == KIND_RES);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= req_type;
            p_reg    <= pos_node;
            n_reg    <= neg_node;
            v_reg    <= element_value;
        end
    end

    mnas_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (recip_start),
        .operand (element_value),
        .done    (recip_done),
        .result  (recip_g)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (req_type == KIND_RES) ? ST_RECIP : ST_LOAD;
                end
            end
            ST_RECIP:
            begin
                if (recip_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        emit_load         = 1'b0;
        branch_count_next = branch_count_reg;
        case (state_reg)
            ST_LOAD:
            begin
                emit_load = 1'b1;
                if (is_branch && !br_full)
                begin
                    branch_count_next = branch_count_reg + 11'd1;
                end
            end
            default:
            begin
                emit_load = 1'b0;
            end
        endcase
    end

    // negative node index means ground
    assign p_live    = !p_reg[10];
    assign n_live    = !n_reg[10];
    assign is_branch = (kind_reg == KIND_VSRC) || (kind_reg == KIND_IND);
    assign br_full   = {6'd0, branch_count_reg} >= 17'(MaxBranches);
    assign brow      = node_count_reg + branch_count_reg;
    assign neg_g     = recip_g ^ SIGN_BIT;

    // stamp list for the held element
    always_comb
    begin
        list       = '0;
        list_count = '0;
        case (kind_reg)
            KIND_RES:
            begin
                if (p_live && n_live)
                begin
                    list[0]    = mk_stamp(1'b0, p_reg, p_reg, recip_g);
                    list[1]    = mk_stamp(1'b0, n_reg, n_reg, recip_g);
                    list[2]    = mk_stamp(1'b0, p_reg, n_reg, neg_g);
                    list[3]    = mk_stamp(1'b0, n_reg, p_reg, neg_g);
                    list_count = 3'd4;
                end
                else if (n_live)
                begin
                    list[0]    = mk_stamp(1'b0, n_reg, n_reg, recip_g);
                    list_count = 3'd1;
                end
                else if (p_live)
                begin
                    list[0]    = mk_stamp(1'b0, p_reg, p_reg, recip_g);
                    list_count = 3'd1;
                end
            end
            KIND_ISRC:
            begin
                if (p_live)
                begin
                    list[list_count] = mk_stamp(1'b1, p_reg, 11'd0, v_reg ^ SIGN_BIT);
                    list_count       = list_count + 3'd1;
                end
                if (n_live)
                begin
                    list[list_count] = mk_stamp(1'b1, n_reg, 11'd0, v_reg);
                    list_count       = list_count + 3'd1;
                end
            end
            KIND_VSRC, KIND_IND:
            begin
                if (br_full)
                begin
                    // dropped element: one all-zero transaction with the flag
                    list[0].ovf = 1'b1;
                    list_count  = 3'd1;
                end
                else
                begin
                    if (p_live)
                    begin
                        list[list_count] = mk_stamp(1'b0, brow, p_reg, ONE_BITS);
                        list_count       = list_count + 3'd1;
                        list[list_count] = mk_stamp(1'b0, p_reg, brow, ONE_BITS);
                        list_count       = list_count + 3'd1;
                    end
                    if (n_live)
                    begin
                        list[list_count] = mk_stamp(1'b0, brow, n_reg, ONE_BITS | SIGN_BIT);
                        list_count       = list_count + 3'd1;
                        list[list_count] = mk_stamp(1'b0, n_reg, brow, ONE_BITS | SIGN_BIT);
                        list_count       = list_count + 3'd1;
                    end
                    if (kind_reg == KIND_VSRC)
                    begin
                        list[list_count] = mk_stamp(1'b1, brow, 11'd0, v_reg);
                        list_count       = list_count + 3'd1;
                    end
                end
            end
            default:
            begin
                list_count = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            branch_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            branch_count_reg <= branch_count_next;
        end
    end

    mnas_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .list      (list),
        .count     (list_count),
        .out_stall (out_stall),
        .out_valid (emit_busy),
        .entry     (emit_entry),
        .last      (last)
    );

    assign out_valid       = emit_busy;
    assign to_rhs          = emit_entry.to_rhs;
    assign row             = emit_entry.row;
    assign column          = emit_entry.column;
    assign entry_value     = emit_entry.value;
    assign branch_overflow = emit_entry.ovf;

    // results only appear while the sequencer is draining the list
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_EMIT)
        else $error("result transaction outside emit phase");

    // branch counter moves only on a list load
    a_branch_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(branch_count_reg) |-> $past(state_reg == ST_LOAD))
        else $error("branch counter changed outside load");

    // an overflow transaction is always the only one of its element
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_overflow |-> last)
        else $error("overflow transaction not marked last");

endmodule
